@@ hdl/clas_pkg.sv @@
// shared types and constants for the command line argument splitter
`timescale 1ns / 1ps
`default_nettype none

package clas_pkg;

    localparam int MAX_RES = 4;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int RES_W   = $clog2(MAX_RES);

    localparam logic [1:0] KIND_RUN  = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_AP    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_CARET = 8'h5e;
    localparam logic [7:0] CH_PIPE  = 8'h7c;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_QUOTED = 3'b010,
        MODE_CARET  = 3'b100
    } mode_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [7:0]  rep;
        logic [15:0] tot;
    } res_t;

    typedef struct packed {
        logic [RES_W-1:0]         last_idx;
        res_t [MAX_RES-1:0]       res;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } q_wr_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_rd_t;

    function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] ch,
                                    input logic [7:0] rep, input logic [15:0] tot);
        res_t r;
        r.kind = kind;
        r.ch   = ch;
        r.rep  = rep;
        r.tot  = tot;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/clas_front.sv @@
// front end: parse state, classification and result bundling per input word
`timescale 1ns / 1ps
`default_nettype none

module clas_front
    import clas_pkg::*;
#(
    parameter int MAX_BACKSLASH_RUN = 255,
    parameter int MAX_ARGS          = 65535
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    input  wire logic [7:0] code_unit,
    input  wire logic       unit_valid,
    input  wire logic       line_end,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    output q_wr_t           q_wr
);

    localparam logic [7:0]  BS_CAP  = (MAX_BACKSLASH_RUN > 255) ? 8'd255
                                                                : 8'(MAX_BACKSLASH_RUN);
    localparam logic [15:0] ARG_CAP = 16'(MAX_ARGS);

    logic        apos_reg;
    mode_t       mode_reg, mode_next;
    logic        qa_reg, qa_next;
    logic [7:0]  bsc_reg, bsc_next;
    logic        has_reg, has_next;
    logic [15:0] cnt_reg, cnt_next;

    logic [2:0]  n_v;
    entry_t      ent;
    logic        flush_all, flush_half, emit, endarg, addbs, quote_hit, opening;
    logic [7:0]  rep;
    logic [7:0]  qch;

    always_comb
    begin
        mode_next  = mode_reg;
        qa_next    = qa_reg;
        bsc_next   = bsc_reg;
        has_next   = has_reg;
        cnt_next   = cnt_reg;
        n_v        = 3'd0;
        ent        = '0;
        flush_all  = 1'b0;
        flush_half = 1'b0;
        emit       = 1'b0;
        endarg     = 1'b0;
        addbs      = 1'b0;
        quote_hit  = 1'b0;
        opening    = 1'b0;
        rep        = 8'd0;
        qch        = qa_reg ? CH_AP : CH_DQ;

        if (unit_valid)
        begin
            case (mode_reg)
                MODE_CARET:
                begin
                    mode_next = MODE_NORMAL;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase

            if (mode_reg == MODE_CARET &&
                code_unit inside {CH_CARET, CH_PIPE, CH_AMP, CH_LT, CH_GT})
            begin
                flush_all = 1'b1;
                emit      = 1'b1;
            end
            else if (mode_reg == MODE_QUOTED)
            begin
                if (code_unit == qch)
                    quote_hit = 1'b1;
                else if (code_unit == CH_BSL)
                    addbs = 1'b1;
                else
                begin
                    flush_all = 1'b1;
                    emit      = 1'b1;
                end
            end
            else
            begin
                if (code_unit inside {CH_SPACE, [CH_TAB:CH_CR]})
                begin
                    flush_all = 1'b1;
                    endarg    = 1'b1;
                end
                else if (code_unit == CH_CARET)
                    mode_next = MODE_CARET;
                else if (code_unit == CH_DQ || (apos_reg && code_unit == CH_AP))
                begin
                    quote_hit = 1'b1;
                    opening   = 1'b1;
                end
                else if (code_unit == CH_BSL)
                    addbs = 1'b1;
                else
                begin
                    flush_all = 1'b1;
                    emit      = 1'b1;
                end
            end

            if (quote_hit)
            begin
                flush_half = 1'b1;
                if (bsc_reg[0])
                    emit = 1'b1;
                else if (opening)
                begin
                    mode_next = MODE_QUOTED;
                    qa_next   = (code_unit == CH_AP);
                end
                else
                    mode_next = MODE_NORMAL;
            end
        end

        // pending backslashes go out first
        if (flush_all || flush_half)
        begin
            rep = flush_half ? (bsc_next >> 1) : bsc_next;
            if (rep != 8'd0)
            begin
                ent.res[n_v[RES_W-1:0]] = mk_res(KIND_RUN, CH_BSL, rep, 16'd0);
                n_v      = n_v + 3'd1;
                has_next = 1'b1;
            end
            bsc_next = 8'd0;
        end

        if (emit)
        begin
            ent.res[n_v[RES_W-1:0]] = mk_res(KIND_RUN, code_unit, 8'd1, 16'd0);
            n_v      = n_v + 3'd1;
            has_next = 1'b1;
        end

        if (endarg)
        begin
            if (has_next)
            begin
                ent.res[n_v[RES_W-1:0]] = mk_res(KIND_END, 8'd0, 8'd0, 16'd0);
                n_v = n_v + 3'd1;
                if (cnt_next < ARG_CAP)
                    cnt_next = cnt_next + 16'd1;
            end
            has_next = 1'b0;
        end

        if (addbs && bsc_next < BS_CAP)
            bsc_next = bsc_next + 8'd1;

        // line end: flush, close argument, report count, back to reset state
        if (line_end)
        begin
            if (bsc_next != 8'd0)
            begin
                ent.res[n_v[RES_W-1:0]] = mk_res(KIND_RUN, CH_BSL, bsc_next, 16'd0);
                n_v      = n_v + 3'd1;
                has_next = 1'b1;
            end
            if (has_next)
            begin
                ent.res[n_v[RES_W-1:0]] = mk_res(KIND_END, 8'd0, 8'd0, 16'd0);
                n_v = n_v + 3'd1;
                if (cnt_next < ARG_CAP)
                    cnt_next = cnt_next + 16'd1;
            end
            ent.res[n_v[RES_W-1:0]] = mk_res(KIND_DONE, 8'd0, 8'd0, cnt_next);
            n_v       = n_v + 3'd1;
            mode_next = MODE_NORMAL;
            qa_next   = 1'b0;
            bsc_next  = 8'd0;
            has_next  = 1'b0;
            cnt_next  = 16'd0;
        end

        ent.last_idx  = RES_W'(n_v - 3'd1);
        q_wr.push     = in_fire && (n_v != 3'd0);
        q_wr.entry    = ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apos_reg <= 1'b1;
            mode_reg <= MODE_NORMAL;
            qa_reg   <= 1'b0;
            bsc_reg  <= 8'd0;
            has_reg  <= 1'b0;
            cnt_reg  <= 16'd0;
        end
        else
        begin
            if (cfg_wr_en)
                apos_reg <= cfg_wr_data;
            if (in_fire)
            begin
                mode_reg <= mode_next;
                qa_reg   <= qa_next;
                bsc_reg  <= bsc_next;
                has_reg  <= has_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    a_bs_cap: assert property (@(posedge clk) disable iff (!rst_n)
        bsc_reg <= BS_CAP)
        else $error("backslash count above cap");

    a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && line_end) |=> (cnt_reg == 16'd0 && mode_reg == MODE_NORMAL &&
                                   bsc_reg == 8'd0 && !has_reg))
        else $error("state not cleared after line end");

endmodule

`default_nettype wire

@@ hdl/clas_queue.sv @@
// short queue of result bundles between front and back
`timescale 1ns / 1ps
`default_nettype none

module clas_queue
    import clas_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire q_wr_t q_wr,
    input  wire logic  pop,
    output q_rd_t      q_rd,
    output logic       full
);

    entry_t             mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               push_ok;
    logic               pop_ok;

    assign full          = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign q_rd.valid    = (count_reg != '0);
    assign q_rd.entry    = mem[rd_ptr_reg];
    assign push_ok       = q_wr.push && !full;
    assign pop_ok        = pop && q_rd.valid;

    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem[wr_ptr_reg] <= q_wr.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop_ok)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push_ok && !pop_ok)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (pop_ok && !push_ok)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !full)
        else $error("push into full queue");

endmodule

`default_nettype wire

@@ hdl/clas_back.sv @@
// back end: unpacks result bundles into one output word per cycle while out_stall is low
`timescale 1ns / 1ps
`default_nettype none

module clas_back
    import clas_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire q_rd_t q_rd,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [1:0] result_kind,
    output logic [7:0] out_char,
    output logic [7:0] repeat_count,
    output logic [15:0] arg_total,
    output logic       last_of_item
);

    logic [RES_W-1:0] pos_reg;
    logic             valid_reg;
    res_t             res_reg;
    logic             last_reg;
    logic             load;
    logic             at_last;

    assign load    = q_rd.valid && (!valid_reg || !out_stall);
    assign at_last = (pos_reg == q_rd.entry.last_idx);
    assign pop     = load && at_last;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= q_rd.entry.res[pos_reg];
            last_reg <= at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
            if (load)
                pos_reg <= at_last ? '0 : pos_reg + RES_W'(1);
        end
    end

    assign out_valid    = valid_reg;
    assign result_kind  = res_reg.kind;
    assign out_char     = res_reg.ch;
    assign repeat_count = res_reg.rep;
    assign arg_total    = res_reg.tot;
    assign last_of_item = last_reg;

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.kind == KIND_DONE) |-> last_reg)
        else $error("line done word not last of item");

    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_rd.valid |-> pos_reg == '0)
        else $error("partial bundle left with empty queue");

endmodule

`default_nettype wire

@@ hdl/command_line_arg_splitter_unit.sv @@
// top level of the command line argument splitter
//
//   channel | ports                                   | dir | moves
//   --------+-----------------------------------------+-----+---------------------------
//   in      | in_valid, in_stall, code_unit,          | in  | one character or line end
//           | unit_valid, line_end                    |     |
//   out     | out_valid, out_stall, result_kind,      | out | one result word
//           | out_char, repeat_count, arg_total,      |     |
//           | last_of_item                            |     |
//   cfg     | cfg_wr_en, cfg_wr_data                  | in  | apostrophe quoting enable
//
// an input word is parsed in the cycle it is accepted; its 0..4 results reach the
// output register from the bundle queue one word per cycle while out_stall is low;
// with out_stall low, sustained rate is one input word per cycle while each yields
// at most one result, as the output register drains the queue one result word per cycle
// reset clears the parse state, queue and output; apostrophe quoting resets to on
// in_stall rises only when the four-entry bundle queue is full
`timescale 1ns / 1ps
`default_nettype none

module command_line_arg_splitter_unit
    import clas_pkg::*;
#(
    parameter int MAX_BACKSLASH_RUN = 255,
    parameter int MAX_ARGS          = 65535
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  code_unit,
    input  wire logic        unit_valid,
    input  wire logic        line_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       result_kind,
    output logic [7:0]       out_char,
    output logic [7:0]       repeat_count,
    output logic [15:0]      arg_total,
    output logic             last_of_item,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data
);

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  pop;
    logic  in_fire;

    assign in_stall = q_full;
    assign in_fire  = in_valid && !q_full;

    clas_front #(
        .MAX_BACKSLASH_RUN (MAX_BACKSLASH_RUN),
        .MAX_ARGS          (MAX_ARGS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .code_unit   (code_unit),
        .unit_valid  (unit_valid),
        .line_end    (line_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_wr        (q_wr)
    );

    clas_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (pop),
        .q_rd  (q_rd),
        .full  (q_full)
    );

    clas_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rd         (q_rd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .out_char     (out_char),
        .repeat_count (repeat_count),
        .arg_total    (arg_total),
        .last_of_item (last_of_item)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the command line argument splitter
`timescale 1ns / 1ps

module testbench;
    import clas_pkg::*;

    typedef enum logic [2:0] {
        PM_NORMAL = 3'b001,
        PM_QUOTED = 3'b010,
        PM_CARET  = 3'b100
    } parse_mode_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  ch;
        logic [7:0]  rep;
        logic [15:0] tot;
        logic        last;
    } arg_result_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  code_unit    = 8'h00;
    logic        unit_valid   = 1'b0;
    logic        line_end     = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  out_char;
    logic [7:0]  repeat_count;
    logic [15:0] arg_total;
    logic        last_of_item;
    logic        cfg_wr_en    = 1'b0;
    logic        cfg_wr_data  = 1'b0;

    // splitter state as the block should hold it
    parse_mode_t mode;
    logic        quote_ap;
    logic        apos_cfg;
    int          bs_count;
    logic        has_chars;
    int          arg_count;

    arg_result_t unit_results[$];
    arg_result_t split_results[$];

    int   errors       = 0;
    int   random_words = 0;
    int   hold_left    = 0;
    logic calm         = 1'b0;

    command_line_arg_splitter_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_unit    (code_unit),
        .unit_valid   (unit_valid),
        .line_end     (line_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .out_char     (out_char),
        .repeat_count (repeat_count),
        .arg_total    (arg_total),
        .last_of_item (last_of_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void add_result(input logic [1:0] kind, input logic [7:0] ch,
                                       input logic [7:0] rep, input logic [15:0] tot);
        arg_result_t r;
        r.kind = kind;
        r.ch   = ch;
        r.rep  = rep;
        r.tot  = tot;
        r.last = 1'b0;
        unit_results = {unit_results, r};
    endfunction

    function automatic void flush_backslashes(input logic all);
        int rep;
        rep = all ? bs_count : (bs_count >> 1);
        if (rep > 0)
        begin
            add_result(KIND_RUN, CH_BSL, 8'(rep), 16'd0);
            has_chars = 1'b1;
        end
        bs_count = 0;
    endfunction

    function automatic void append_char(input logic [7:0] c);
        add_result(KIND_RUN, c, 8'd1, 16'd0);
        has_chars = 1'b1;
    endfunction

    function automatic void close_arg();
        if (has_chars)
        begin
            add_result(KIND_END, 8'd0, 8'd0, 16'd0);
            if (arg_count < 65535)
                arg_count++;
        end
        has_chars = 1'b0;
    endfunction

    function automatic void count_backslash();
        if (bs_count < 255)
            bs_count++;
    endfunction

    function automatic void handle_quote(input logic [7:0] c, input logic opening);
        logic odd;
        odd = bs_count[0];
        flush_backslashes(1'b0);
        if (odd)
            append_char(c);
        else if (opening)
        begin
            mode     = PM_QUOTED;
            quote_ap = (c == CH_AP);
        end
        else
            mode = PM_NORMAL;
    endfunction

    function automatic void handle_normal(input logic [7:0] c);
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
        begin
            flush_backslashes(1'b1);
            close_arg();
        end
        else if (c == CH_CARET)
            mode = PM_CARET;
        else if (c == CH_DQ || (apos_cfg && c == CH_AP))
            handle_quote(c, 1'b1);
        else if (c == CH_BSL)
            count_backslash();
        else
        begin
            flush_backslashes(1'b1);
            append_char(c);
        end
    endfunction

    function automatic void handle_quoted(input logic [7:0] c);
        logic [7:0] q;
        q = quote_ap ? CH_AP : CH_DQ;
        if (c == q)
            handle_quote(c, 1'b0);
        else if (c == CH_BSL)
            count_backslash();
        else
        begin
            flush_backslashes(1'b1);
            append_char(c);
        end
    endfunction

    function automatic void reset_parse();
        mode      = PM_NORMAL;
        quote_ap  = 1'b0;
        bs_count  = 0;
        has_chars = 1'b0;
        arg_count = 0;
    endfunction

    // works out the results of one accepted word and queues them
    function automatic void split_unit(input logic [7:0] cu, input logic uv, input logic le);
        unit_results.delete();
        if (uv)
        begin
            case (mode)
                PM_CARET:
                begin
                    mode = PM_NORMAL;
                    if (cu inside {CH_CARET, CH_PIPE, CH_AMP, CH_LT, CH_GT})
                    begin
                        flush_backslashes(1'b1);
                        append_char(cu);
                    end
                    else
                        handle_normal(cu);
                end
                PM_QUOTED: handle_quoted(cu);
                default:   handle_normal(cu);
            endcase
        end
        if (le)
        begin
            flush_backslashes(1'b1);
            close_arg();
            add_result(KIND_DONE, 8'd0, 8'd0, 16'(arg_count));
            reset_parse();
        end
        if (unit_results.size() > 0)
            unit_results[unit_results.size() - 1].last = 1'b1;
        foreach (unit_results[i])
            split_results = {split_results, unit_results[i]};
    endfunction

    task automatic send_word(input logic [7:0] cu, input logic uv, input logic le);
        while (!calm && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        code_unit  <= cu;
        unit_valid <= uv;
        line_end   <= le;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        split_unit(cu, uv, le);
    endtask

    task automatic send_text(input string s, input logic end_line);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b1, end_line && (i == s.len() - 1));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (split_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_apostrophe_cfg(input logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        apos_cfg = v;
    endtask

    function automatic logic [7:0] random_unit();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return 8'h61 + 8'($urandom_range(25));
        if (r < 50)
            return ($urandom_range(3) == 0) ? 8'(9 + $urandom_range(4)) : CH_SPACE;
        if (r < 62)
            return CH_BSL;
        if (r < 70)
            return CH_DQ;
        if (r < 77)
            return CH_AP;
        if (r < 83)
            return CH_CARET;
        if (r < 90)
        begin
            case ($urandom_range(4))
                0:       return CH_CARET;
                1:       return CH_PIPE;
                2:       return CH_AMP;
                3:       return CH_LT;
                default: return CH_GT;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_line();
        int         len;
        logic       noisy;
        logic [7:0] cu;
        len   = $urandom_range(20);
        noisy = ($urandom_range(9) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(19) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            if (!noisy && $urandom_range(19) == 0)
            begin
                repeat ($urandom_range(6, 2))
                begin
                    send_word(CH_BSL, 1'b1, 1'b0);
                    random_words++;
                end
            end
            cu = noisy ? 8'($urandom) : random_unit();
            random_words++;
            if (i == len - 1 && $urandom_range(1))
            begin
                send_word(cu, 1'b1, 1'b1);
                return;
            end
            send_word(cu, 1'b1, 1'b0);
        end
        send_word(8'($urandom), 1'b0, 1'b1);
        random_words++;
    endtask

    task automatic test_directed();
        send_text("a\\\\\\\"b \\\\\"' \"^|^^^x^", 1'b0);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_text("\\^&'q", 1'b0);
        send_word(CH_CR, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        drain_results();
    endtask

    task automatic test_config_in_quote();
        send_text("'a", 1'b0);
        drain_results();
        write_apostrophe_cfg(1'b0);
        send_text("'\"'b\"", 1'b0);
        send_text(" 'c'", 1'b1);
        drain_results();
        write_apostrophe_cfg(1'b1);
        send_text("'d e'", 1'b1);
        drain_results();
    endtask

    task automatic test_backpressure();
        calm      = 1'b1;
        hold_left = 150;
        repeat (10) send_text("\\^& ", 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        drain_results();
        calm = 1'b0;
    endtask

    task automatic test_random();
        while (random_words < 180)
        begin
            calm = (random_words > 60 && random_words < 120);
            if ($urandom_range(4) == 0)
            begin
                drain_results();
                write_apostrophe_cfg(1'($urandom_range(1)));
            end
            send_random_line();
        end
        drain_results();
        calm = 1'b0;
    endtask

    task automatic check_result();
        arg_result_t e;
        if (split_results.size() == 0)
        begin
            $error("result word with none pending: kind %0d char %0h", result_kind, out_char);
            errors++;
            return;
        end
        e = split_results.pop_front();
        if (result_kind !== e.kind)
        begin
            $error("result_kind: expected %0d, got %0d", e.kind, result_kind);
            errors++;
        end
        if (out_char !== e.ch)
        begin
            $error("out_char: expected %0h, got %0h", e.ch, out_char);
            errors++;
        end
        if (repeat_count !== e.rep)
        begin
            $error("repeat_count: expected %0d, got %0d", e.rep, repeat_count);
            errors++;
        end
        if (arg_total !== e.tot)
        begin
            $error("arg_total: expected %0d, got %0d", e.tot, arg_total);
            errors++;
        end
        if (last_of_item !== e.last)
        begin
            $error("last_of_item: expected %0d, got %0d", e.last, last_of_item);
            errors++;
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_result();
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (!calm && $urandom_range(99) < 33)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        apos_cfg = 1'b1;
        reset_parse();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_config_in_quote();
        write_apostrophe_cfg(1'b0);
        test_backpressure();
        write_apostrophe_cfg(1'b1);
        test_random();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
